### design/ssfs_pkg.sv
// ----------------------------------------------------------------------------
// Shortest seek first scheduler package
// Fixed field widths, constants and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfs_pkg;

   localparam int TRACK_W = 10;   // served_track, track, start_track
   localparam int DIST_W  = 10;   // move_distance
   localparam int SUM_W   = 15;   // total_distance

   localparam logic [TRACK_W-1:0] START_RESET = TRACK_W'(50);
   localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_STEP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic take;
   } nrst_ctrl_type;

endpackage

`default_nettype wire

### design/ssfs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one track request per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssfs_req_if;
   import ssfs_pkg::*;

   logic               valid;
   logic               ready;
   logic [TRACK_W-1:0] track;
   logic               last;

   modport source (output valid, output track, output last, input ready);
   modport sink   (input valid, input track, input last, output ready);
endinterface

`default_nettype wire

### design/ssfs_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one scheduled request per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssfs_rsp_if;
   import ssfs_pkg::*;

   logic               valid;
   logic               ready;
   logic [TRACK_W-1:0] served_track;
   logic [DIST_W-1:0]  move_distance;
   logic [SUM_W-1:0]   total_distance;
   logic               final_res;

   modport source (output valid, output served_track, output move_distance,
                   output total_distance, output final_res, input ready);
   modport sink   (input valid, input served_track, input move_distance,
                   input total_distance, input final_res, output ready);
endinterface

`default_nettype wire

### design/ssfs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfs_ram #(
   parameter int WIDTH  = 10,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/ssfs_nearest.sv
// ----------------------------------------------------------------------------
// Nearest request tracker
// Shared distance and compare unit; keeps the best candidate of a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfs_nearest #(
   parameter int TRACK_BITS = 10,
   parameter int IDX_W      = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ssfs_pkg::nrst_ctrl_type ctrl,
   input  wire logic [TRACK_BITS-1:0]   cand_track,
   input  wire logic [IDX_W-1:0]        cand_idx,
   input  wire logic [TRACK_BITS-1:0]   head,
   output logic      [TRACK_BITS-1:0]   best_track,
   output logic      [TRACK_BITS-1:0]   best_dist,
   output logic      [IDX_W-1:0]        best_idx
);
   import ssfs_pkg::*;

   logic                  best_vld_ff, best_vld_in;
   logic [TRACK_BITS-1:0] best_trk_ff, best_trk_in;
   logic [TRACK_BITS-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [TRACK_BITS-1:0] cand_dist;
   logic                  better;

   always_comb begin
      cand_dist = (cand_track > head) ? (cand_track - head) : (head - cand_track);
      // lower track wins a tie on distance
      better = !best_vld_ff || (cand_dist < best_dist_ff) ||
               ((cand_dist == best_dist_ff) && (cand_track < best_trk_ff));

      best_vld_in  = best_vld_ff;
      best_trk_in  = best_trk_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (ctrl.clear) begin
         best_vld_in = 1'b0;
      end else if (ctrl.take && better) begin
         best_vld_in  = 1'b1;
         best_trk_in  = cand_track;
         best_dist_in = cand_dist;
         best_idx_in  = cand_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_vld_ff <= 1'b0;
      end else begin
         best_vld_ff <= best_vld_in;
      end
      best_trk_ff  <= best_trk_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   assign best_track = best_trk_ff;
   assign best_dist  = best_dist_ff;
   assign best_idx   = best_idx_ff;

endmodule

`default_nettype wire

### design/shortest_seek_first_scheduler_unit.sv
// Loading takes one request per cycle; ready is high only while loading.
// After the request marked last, each result of a batch comes from a walk of the
// request store by the shared compare unit, one entry per cycle behind its
// registered read port, then the step state updates the head. Results wait in
// an output register; the next batch loads after the final one. Reset is
// synchronous: empty batch, start track 50, no result pending.
// ----------------------------------------------------------------------------
// Shortest seek first scheduler
// Batches track requests and emits them in shortest seek first order.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_seek_first_scheduler_unit #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ssfs_req_if.sink                            req_ch,
   ssfs_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [ssfs_pkg::TRACK_W-1:0]   csr_wdata
);
   import ssfs_pkg::*;

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int EXT_W = TRACK_BITS + TRACK_W;
   localparam int ADD_W = ((SUM_W > TRACK_BITS) ? SUM_W : TRACK_BITS) + 1;

   state_type state_ff, state_in;

   logic [TRACK_W-1:0]      start_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [MAX_REQUESTS-1:0] pending_ff, pending_in;
   logic [CNT_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff;
   logic [TRACK_BITS-1:0]   head_ff, head_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;

   logic [TRACK_W-1:0]      out_trk_ff, out_trk_in;
   logic [DIST_W-1:0]       out_dist_ff, out_dist_in;
   logic                    out_final_ff, out_final_in;

   logic                    req_acc, rsp_acc;
   logic                    store_wr;
   logic [TRACK_BITS-1:0]   req_trk, start_trk, rd_data;
   logic [TRACK_BITS-1:0]   best_track, best_dist;
   logic [IDX_W-1:0]        best_idx;
   logic [MAX_REQUESTS-1:0] clr_mask;
   logic [ADD_W-1:0]        sum_wide;
   logic [EXT_W-1:0]        trk_ext, dist_ext, req_ext, start_ext;
   nrst_ctrl_type           nrst_ctrl;

   // mask input and start track to the stored width
   assign req_ext   = EXT_W'(req_ch.track);
   assign start_ext = EXT_W'(start_ff);
   assign req_trk   = req_ext[TRACK_BITS-1:0];
   assign start_trk = start_ext[TRACK_BITS-1:0];

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_acc      = rsp_ch.valid && rsp_ch.ready;
   assign store_wr     = req_acc && (count_ff < CNT_W'(MAX_REQUESTS));

   ssfs_ram #(
      .WIDTH  (TRACK_BITS),
      .DEPTH  (MAX_REQUESTS),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_trk),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   ssfs_nearest #(
      .TRACK_BITS (TRACK_BITS),
      .IDX_W      (IDX_W)
   ) u_nearest (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (nrst_ctrl),
      .cand_track (rd_data),
      .cand_idx   (cmp_idx_ff),
      .head       (head_ff),
      .best_track (best_track),
      .best_dist  (best_dist),
      .best_idx   (best_idx)
   );

   always_comb begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
         clr_mask[i] = (IDX_W'(i) == best_idx);
      end
      sum_wide = ADD_W'(sum_ff) + ADD_W'(best_dist);
      trk_ext  = EXT_W'(best_track);
      dist_ext = EXT_W'(best_dist);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = 1'b0;
      head_in      = head_ff;
      sum_in       = sum_ff;
      out_trk_in   = out_trk_ff;
      out_dist_in  = out_dist_ff;
      out_final_in = out_final_ff;
      nrst_ctrl    = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (store_wr) begin
               pending_in[count_ff[IDX_W-1:0]] = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            if (req_acc && req_ch.last) begin
               head_in     = start_trk;
               sum_in      = '0;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read issued this cycle is compared in the next one
            cmp_vld_in     = (scan_idx_ff < count_ff);
            nrst_ctrl.take = cmp_vld_ff && pending_ff[cmp_idx_ff];
            if (scan_idx_ff == count_ff) begin
               state_in = ST_STEP;
            end else begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
         end
         ST_STEP: begin
            nrst_ctrl.clear = 1'b1;
            pending_in      = pending_ff & ~clr_mask;
            head_in         = best_track;
            sum_in          = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX
                                                           : sum_wide[SUM_W-1:0];
            out_trk_in      = trk_ext[TRACK_W-1:0];
            out_dist_in     = dist_ext[DIST_W-1:0];
            out_final_in    = ((pending_ff & ~clr_mask) == '0);
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               scan_idx_in = '0;
               if (out_final_ff) begin
                  count_in   = '0;
                  pending_in = '0;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         start_ff   <= START_RESET;
         count_ff   <= '0;
         pending_ff <= '0;
         cmp_vld_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         cmp_vld_ff <= cmp_vld_in;
         sum_ff     <= sum_in;
         if (csr_we) begin
            start_ff <= csr_wdata;
         end
      end
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= scan_idx_ff[IDX_W-1:0];
      head_ff      <= head_in;
      out_trk_ff   <= out_trk_in;
      out_dist_ff  <= out_dist_in;
      out_final_ff <= out_final_in;
   end

   assign rsp_ch.valid          = (state_ff == ST_EMIT);
   assign rsp_ch.served_track   = out_trk_ff;
   assign rsp_ch.move_distance  = out_dist_ff;
   assign rsp_ch.total_distance = sum_ff;
   assign rsp_ch.final_res      = out_final_ff;

endmodule

`default_nettype wire
